// ===== sv/pid_clamped_windowed_derivative_core_macros.svh =====
// Assertion macros shared by the PID core RTL.
`ifndef PID_CLAMPED_WINDOWED_DERIVATIVE_CORE_MACROS_SVH
`define PID_CLAMPED_WINDOWED_DERIVATIVE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCWD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcwd same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcwd next-cycle check failed");

`endif

// ===== sv/pcwd_pkg.sv =====
// Types and constants for the clamped-integrator windowed-derivative PID core.
`timescale 1ns / 1ps

package pcwd_pkg;

   localparam int MEAS_W     = 16;
   localparam int TARGET_W   = 10;
   localparam int GAIN_W     = 16;
   localparam int ERR_W      = 18;
   localparam int INT_W      = 14;
   localparam int DELTA_W    = 19;
   localparam int DRIVE_W    = 16;
   localparam int FRAC_SHIFT = 4;    // whole degrees to Q.4
   localparam int PROD_SHIFT = 12;   // Q.12 sum to whole units

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int INTEGRAL_LIMIT = 4096;
   localparam int TARGET_JUMP    = 10;
   localparam int ROUND_BIAS     = 4095;
   localparam int HALF_MAX       = 16383;
   localparam int HALF_MIN       = -16384;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7FFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;

   typedef enum logic [0:0] {
      OP_SAMPLE = 1'b0,
      OP_TARGET = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PGAIN = 2'd0,
      CSR_IGAIN = 2'd1,
      CSR_DGAIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gains_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      saturated;
   } result_type;

endpackage

// ===== sv/pcwd_req_if.sv =====
// Request channel: sample or target beat.
`timescale 1ns / 1ps

interface pcwd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   opcode;
   logic signed [pcwd_pkg::MEAS_W-1:0]     measured_value;
   logic        [pcwd_pkg::TARGET_W-1:0]   new_target;

   modport source (output valid, output opcode, output measured_value,
                   output new_target, input ready);
   modport sink   (input valid, input opcode, input measured_value,
                   input new_target, output ready);
endinterface

// ===== sv/pcwd_rsp_if.sv =====
// Response channel: drive beat.
`timescale 1ns / 1ps

interface pcwd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pcwd_pkg::DRIVE_W-1:0]  drive;
   logic                                 saturated;

   modport source (output valid, output drive, output saturated, input ready);
   modport sink   (input valid, input drive, input saturated, output ready);
endinterface

// ===== sv/pcwd_drive_calc.sv =====
// Gain products, truncation toward zero, doubling and saturation of the drive.
`timescale 1ns / 1ps

module pcwd_drive_calc #(
   parameter int TOTAL_W = 21
) (
   input  logic signed [pcwd_pkg::ERR_W-1:0] err,
   input  logic signed [pcwd_pkg::INT_W-1:0] integral,
   input  logic signed [TOTAL_W-1:0]         total,
   input  pcwd_pkg::gains_type               gains,
   output pcwd_pkg::result_type              result
);

   localparam int GS_W    = pcwd_pkg::GAIN_W + 1;
   localparam int PP_W    = pcwd_pkg::ERR_W + GS_W;
   localparam int PI_W    = pcwd_pkg::INT_W + GS_W;
   localparam int PD_W    = TOTAL_W + GS_W;
   localparam int SUM_W   = PD_W + 2;
   localparam int WHOLE_W = SUM_W - pcwd_pkg::PROD_SHIFT;

   localparam logic signed [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(pcwd_pkg::HALF_MAX);
   localparam logic signed [WHOLE_W-1:0] WHOLE_MIN = WHOLE_W'(pcwd_pkg::HALF_MIN);

   logic signed [GS_W-1:0]    kp_s;
   logic signed [GS_W-1:0]    ki_s;
   logic signed [GS_W-1:0]    kd_s;
   logic signed [PP_W-1:0]    prod_p;
   logic signed [PI_W-1:0]    prod_i;
   logic signed [PD_W-1:0]    prod_d;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   biased;
   logic signed [WHOLE_W-1:0] whole;

   always_comb begin
      kp_s   = $signed({1'b0, gains.kp});
      ki_s   = $signed({1'b0, gains.ki});
      kd_s   = $signed({1'b0, gains.kd});
      prod_p = err * kp_s;
      prod_i = integral * ki_s;
      prod_d = total * kd_s;
      sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
      // truncate toward zero: bias negatives before the arithmetic shift
      biased = sum[SUM_W-1] ? sum + SUM_W'(pcwd_pkg::ROUND_BIAS) : sum;
      whole  = WHOLE_W'(biased >>> pcwd_pkg::PROD_SHIFT);

      priority if (whole > WHOLE_MAX) begin
         result.drive     = pcwd_pkg::DRIVE_MAX;
         result.saturated = 1'b1;
      end else if (whole < WHOLE_MIN) begin
         result.drive     = pcwd_pkg::DRIVE_MIN;
         result.saturated = 1'b1;
      end else begin
         result.drive     = {whole[pcwd_pkg::DRIVE_W-2:0], 1'b0};
         result.saturated = 1'b0;
      end
   end

endmodule

// ===== sv/pid_clamped_windowed_derivative_core.sv =====
// PID core: state update at accept, operand register, drive computation, result register.
// A sample beat's operands are captured in the operand register at accept, and its drive in the result register.
// Throughput: one beat per cycle while the result register is not stalled; the state registers update at accept.
// Target beats update the setpoint (and may clear the dynamics) and give no response.
// Synchronous reset clears the gains, setpoint, integrator, delta ring and the valid bits of both stages.
`timescale 1ns / 1ps
`include "pid_clamped_windowed_derivative_core_macros.svh"

module pid_clamped_windowed_derivative_core #(
   parameter int WINDOW = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pcwd_req_if.sink                              req_bus,
   pcwd_rsp_if.source                            rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [pcwd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pcwd_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TOTAL_W = pcwd_pkg::DELTA_W + $clog2(WINDOW);
   localparam int ISUM_W  = pcwd_pkg::ERR_W + 1;
   localparam int DIFF_W  = pcwd_pkg::TARGET_W + 1;

   localparam logic signed [ISUM_W-1:0] ILIM_HI = ISUM_W'(pcwd_pkg::INTEGRAL_LIMIT);
   localparam logic signed [ISUM_W-1:0] ILIM_LO = ISUM_W'(-pcwd_pkg::INTEGRAL_LIMIT);
   localparam logic signed [DIFF_W-1:0] JUMP_HI = DIFF_W'(pcwd_pkg::TARGET_JUMP);
   localparam logic signed [DIFF_W-1:0] JUMP_LO = DIFF_W'(-pcwd_pkg::TARGET_JUMP);

   // configuration
   pcwd_pkg::gains_type gains_ff, gains_in;

   // controller state
   logic [pcwd_pkg::TARGET_W-1:0]        setpoint_ff, setpoint_in;
   logic signed [pcwd_pkg::INT_W-1:0]    integral_ff, integral_in;
   logic signed [pcwd_pkg::ERR_W-1:0]    prev_err_ff, prev_err_in;
   logic signed [pcwd_pkg::DELTA_W-1:0]  ring_ff [WINDOW];
   logic [POS_W-1:0]                     pos_ff, pos_in;
   logic signed [TOTAL_W-1:0]            total_ff, total_in;

   // operand stage and result stage
   logic                                 s1_valid_ff, s1_valid_in;
   logic signed [pcwd_pkg::ERR_W-1:0]    s1_err_ff;
   logic signed [pcwd_pkg::INT_W-1:0]    s1_int_ff;
   logic signed [TOTAL_W-1:0]            s1_total_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   pcwd_pkg::result_type                 rsp_ff, calc_result;

   logic                                 accept;
   logic                                 sample_accept;
   logic                                 target_accept;
   logic                                 rsp_advance;
   logic                                 jump;
   logic signed [pcwd_pkg::ERR_W-1:0]    err;
   logic signed [ISUM_W-1:0]             isum;
   logic signed [pcwd_pkg::DELTA_W-1:0]  delta;
   logic signed [DIFF_W-1:0]             diff;

   logic                                 int_in_range;
   logic                                 drive_at_rail;
   logic                                 dyn_cleared;

   // ---------------------------------------------------------------- handshake
   assign rsp_advance   = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || rsp_advance;
   assign accept        = req_bus.valid && req_bus.ready;
   assign sample_accept = accept && (req_bus.opcode == pcwd_pkg::OP_SAMPLE);
   assign target_accept = accept && (req_bus.opcode == pcwd_pkg::OP_TARGET);

   always_comb begin
      s1_valid_in  = sample_accept ? 1'b1 : (rsp_advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = rsp_advance ? s1_valid_ff : rsp_valid_ff;
   end

   // ---------------------------------------------------------------- gains
   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pcwd_pkg::CSR_PGAIN: gains_in.kp = csr_write_data;
            pcwd_pkg::CSR_IGAIN: gains_in.ki = csr_write_data;
            pcwd_pkg::CSR_DGAIN: gains_in.kd = csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- state update
   always_comb begin
      err   = $signed({4'b0, setpoint_ff, pcwd_pkg::FRAC_SHIFT'(0)})
              - pcwd_pkg::ERR_W'(req_bus.measured_value);
      isum  = ISUM_W'(integral_ff) + ISUM_W'(err);
      delta = pcwd_pkg::DELTA_W'(err) - pcwd_pkg::DELTA_W'(prev_err_ff);
      diff  = $signed({1'b0, setpoint_ff}) - $signed({1'b0, req_bus.new_target});
      jump  = (diff > JUMP_HI) || (diff < JUMP_LO);

      setpoint_in = setpoint_ff;
      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;

      if (sample_accept) begin
         priority if (isum > ILIM_HI) begin
            integral_in = pcwd_pkg::INT_W'(ILIM_HI);
         end else if (isum < ILIM_LO) begin
            integral_in = pcwd_pkg::INT_W'(ILIM_LO);
         end else begin
            integral_in = pcwd_pkg::INT_W'(isum);
         end
         prev_err_in = err;
         // oldest delta leaves the window, newest enters
         total_in    = total_ff - TOTAL_W'(ring_ff[pos_ff]) + TOTAL_W'(delta);
         pos_in      = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + POS_W'(1);
      end else if (target_accept) begin
         setpoint_in = req_bus.new_target;
         if (jump) begin
            integral_in = '0;
            prev_err_in = '0;
            pos_in      = '0;
            total_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff     <= '0;
         setpoint_ff  <= '0;
         integral_ff  <= '0;
         prev_err_ff  <= '0;
         pos_ff       <= '0;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gains_ff     <= gains_in;
         setpoint_ff  <= setpoint_in;
         integral_ff  <= integral_in;
         prev_err_ff  <= prev_err_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (target_accept && jump) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (sample_accept) begin
         ring_ff[pos_ff] <= delta;
      end
   end

   // ---------------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      if (sample_accept) begin
         s1_err_ff   <= err;
         s1_int_ff   <= integral_in;
         s1_total_ff <= total_in;
      end
      if (rsp_advance && s1_valid_ff) begin
         rsp_ff <= calc_result;
      end
   end

   pcwd_drive_calc #(
      .TOTAL_W (TOTAL_W)
   ) u_drive_calc (
      .err      (s1_err_ff),
      .integral (s1_int_ff),
      .total    (s1_total_ff),
      .gains    (gains_ff),
      .result   (calc_result)
   );

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.drive     = rsp_ff.drive;
   assign rsp_bus.saturated = rsp_ff.saturated;

   // ---------------------------------------------------------------- assertions
   assign int_in_range  = (integral_ff <= pcwd_pkg::INTEGRAL_LIMIT)
                          && (integral_ff >= -pcwd_pkg::INTEGRAL_LIMIT);
   assign drive_at_rail = (rsp_bus.drive == pcwd_pkg::DRIVE_MAX)
                          || (rsp_bus.drive == pcwd_pkg::DRIVE_MIN);
   assign dyn_cleared   = (integral_ff == '0) && (total_ff == '0) && (pos_ff == '0)
                          && (prev_err_ff == '0);

   `PCWD_ASSERT_IMPL(a_int_clamped, clock, reset, 1'b1, int_in_range)
   `PCWD_ASSERT_IMPL(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_W'(WINDOW - 1))
   `PCWD_ASSERT_IMPL(a_sat_drive, clock, reset, rsp_bus.valid && rsp_bus.saturated, drive_at_rail)
   `PCWD_ASSERT_NEXT(a_jump_clears, clock, reset, target_accept && jump, dyn_cleared)

endmodule
